/* hw/rtl/qfts_pkg.sv */
`timescale 1ns / 1ps

package qfts_pkg;

  // Candidate store geometry
  localparam int unsigned MAX_CANDIDATES = 16;
  localparam int unsigned IDX_W          = $clog2(MAX_CANDIDATES);
  localparam int unsigned CNT_W          = $clog2(MAX_CANDIDATES + 1);

  // Field widths
  localparam int unsigned COORD_W = 15;
  localparam int unsigned RW_W    = 8;
  localparam int unsigned MS_W    = 12;
  localparam int unsigned MSR_W   = 8;

  typedef struct packed {
    logic [COORD_W-1:0] size;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } cand_t;

  localparam int unsigned CAND_W = $bits(cand_t);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO_WEIGHT   = 2'd0,
    REG_MIN_SPACING    = 2'd1,
    REG_MAX_SIDE_RATIO = 2'd2
  } cfg_reg_e;

  localparam logic [RW_W-1:0]  RW_RESET  = 8'd64;
  localparam logic [MS_W-1:0]  MS_RESET  = 12'd160;
  localparam logic [MSR_W-1:0] MSR_RESET = 8'd96;

  // Shared arithmetic units
  localparam int unsigned SQ_IN_W  = 64;
  localparam int unsigned SQ_OUT_W = 32;
  localparam int unsigned DIV_N_W  = 48;
  localparam int unsigned DIV_D_W  = 32;

  // Fixed point limits
  localparam logic [16:0] COS_ONE  = 17'h10000;
  localparam logic [31:0] PEN_SAT  = 32'hFFFF_0000;

endpackage

/* hw/rtl/qfts_cfg_if.sv */
`timescale 1ns / 1ps

interface qfts_cfg_if import qfts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/qfts_cand_if.sv */
`timescale 1ns / 1ps

interface qfts_cand_if import qfts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] cand_x;
  logic [COORD_W-1:0] cand_y;
  logic [COORD_W-1:0] cand_size;
  logic               last;

  modport source (output valid, output cand_x, output cand_y, output cand_size,
                  output last, input ready);
  modport sink   (input valid, input cand_x, input cand_y, input cand_size,
                  input last, output ready);
endinterface

/* hw/rtl/qfts_res_if.sv */
`timescale 1ns / 1ps

interface qfts_res_if import qfts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [COORD_W-1:0] tl_x;
  logic [COORD_W-1:0] tl_y;
  logic [COORD_W-1:0] tr_x;
  logic [COORD_W-1:0] tr_y;
  logic [COORD_W-1:0] bl_x;
  logic [COORD_W-1:0] bl_y;
  logic [COORD_W-1:0] tl_size;
  logic [COORD_W-1:0] tr_size;
  logic [COORD_W-1:0] bl_size;

  modport source (output valid, output found, output tl_x, output tl_y,
                  output tr_x, output tr_y, output bl_x, output bl_y,
                  output tl_size, output tr_size, output bl_size, input ready);
  modport sink   (input valid, input found, input tl_x, input tl_y,
                  input tr_x, input tr_y, input bl_x, input bl_y,
                  input tl_size, input tr_size, input bl_size, output ready);
endinterface

/* hw/rtl/qfts_ram.sv */
`timescale 1ns / 1ps

module qfts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/qfts_isqrt.sv */
`timescale 1ns / 1ps

module qfts_isqrt import qfts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SQ_IN_W-1:0]  rad_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [SQ_OUT_W-1:0] root_o
);

  logic               busy_q;
  logic               done_q;
  logic [SQ_IN_W-1:0] v_q;
  logic [SQ_IN_W-1:0] r_q;
  logic [SQ_IN_W-1:0] bit_q;
  logic [SQ_IN_W-1:0] trial;
  logic               take;

  // one result bit per cycle, floor root
  assign trial = r_q + bit_q;
  assign take  = (v_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bit_q == SQ_IN_W'(1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= rad_i;
      r_q   <= '0;
      bit_q <= SQ_IN_W'(1) << (SQ_IN_W - 2);
    end else if (busy_q) begin
      if (take) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = r_q[SQ_OUT_W-1:0];

endmodule

/* hw/rtl/qfts_div.sv */
`timescale 1ns / 1ps

module qfts_div import qfts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(DIV_N_W);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  cnt_q;
  logic [DIV_N_W-1:0] num_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_D_W-1:0] den_q;
  logic [DIV_D_W:0]   shifted;
  logic               ge;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, num_q[DIV_N_W-1]};
  assign ge      = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(DIV_N_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_N_W-2:0], ge};
      rem_q <= ge ? DIV_D_W'(shifted - {1'b0, den_q}) : shifted[DIV_D_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

/* hw/rtl/qr_finder_triple_select_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// cfg_i     in   valid/ready    index, data (ratio_weight, min_spacing, max_side_ratio)
// cand_i    in   valid/ready    cand_x, cand_y, cand_size, last
// res_o     out  valid/ready    found, tl/tr/bl x and y, tl/tr/bl size
//
// An accepted candidate is written into the store while it has room. The item
// flagged last starts the search over all C(n,3) triples; a triple that fails
// the spacing or ratio test is skipped, any other goes through three corners,
// two leg roots and a penalty divide on the 32-step square root unit and the
// 48-step divider, shared by all corners. Reset clears the count, the search
// state and the result valid flag; the store needs no clearing. cand_i is not
// ready during a search; a held result on res_o does not block loading, only
// the hand-off of the next result.

module qr_finder_triple_select_top import qfts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  qfts_cfg_if.sink   cfg_i,
  qfts_cand_if.sink  cand_i,
  qfts_res_if.source res_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_I, S_RD_J, S_RD_K, S_RD_W, S_DIST, S_TEST, S_DOT, S_PROD,
    S_ROOT, S_COSDIV, S_SEL, S_LEG1, S_LEG2, S_PEN, S_PENDIV, S_SCORE,
    S_LABEL, S_CROSS, S_EMIT
  } state_e;

  // corner and side codes within a triple
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;
  localparam logic [1:0] SIDE_AB  = 2'd0;
  localparam logic [1:0] SIDE_BC  = 2'd1;
  localparam logic [1:0] SIDE_AC  = 2'd2;

  function automatic logic signed [COORD_W:0] sdiff(logic [COORD_W-1:0] a,
                                                   logic [COORD_W-1:0] b);
    sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  state_e state_q;

  // configuration
  logic [RW_W-1:0]  ratio_weight_q;
  logic [MS_W-1:0]  min_spacing_q;
  logic [MSR_W-1:0] max_side_ratio_q;
  logic [23:0]      ms2_q;
  logic [15:0]      r2_q;

  // loop state
  logic [CNT_W-1:0] cnt_q, n_q, i_q, j_q, k_q;
  logic [1:0]       step_q;
  cand_t            ea_q, eb_q, ec_q;
  logic [31:0]      d_q [3];
  logic signed [32:0] dot_q;
  logic [16:0]      cos_q [3];
  logic [16:0]      cmin_q;
  logic [31:0]      dpr_q;
  logic [19:0]      l1_q, l2_q;
  logic [31:0]      pen_q;

  // best triple
  logic [31:0]      best_score_q;
  logic             best_valid_q;
  cand_t            bea_q, beb_q, bec_q;
  logic [16:0]      bcos_q [3];
  cand_t            lt_q, lp1_q, lp2_q;

  // result register
  logic             res_valid_q;
  logic             res_found_q;
  cand_t            res_tl_q, res_tr_q, res_bl_q;

  // store and shared units
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [CAND_W-1:0]     ram_rdata;
  logic                  sq_start, sq_busy, sq_done;
  logic [SQ_IN_W-1:0]    sq_rad;
  logic [SQ_OUT_W-1:0]   sq_root;
  logic                  dv_start, dv_busy, dv_done;
  logic [DIV_N_W-1:0]    dv_num;
  logic [DIV_D_W-1:0]    dv_den;
  logic [DIV_N_W-1:0]    dv_quo;

  logic cand_acc, has_room;
  logic [CNT_W-1:0] n_new;

  assign cand_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign cand_acc     = cand_i.valid && cand_i.ready;
  assign has_room     = (cnt_q < CNT_W'(MAX_CANDIDATES));
  assign ram_we       = cand_acc && has_room;
  assign n_new        = has_room ? cnt_q + CNT_W'(1) : cnt_q;

  qfts_ram #(
    .WIDTH (CAND_W),
    .DEPTH (MAX_CANDIDATES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({cand_i.cand_size, cand_i.cand_y, cand_i.cand_x}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  qfts_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  qfts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .busy_o  (dv_busy),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  // squared side length for the current side
  cand_t dp, dq;
  logic signed [COORD_W:0] dx, dy;
  logic signed [31:0] sqx, sqy;
  logic [31:0] dist_w;

  always_comb begin
    case (step_q)
      SIDE_AB: begin dp = ea_q; dq = eb_q; end
      SIDE_BC: begin dp = eb_q; dq = ec_q; end
      default: begin dp = ea_q; dq = ec_q; end
    endcase
    dx     = sdiff(dp.x, dq.x);
    dy     = sdiff(dp.y, dq.y);
    sqx    = dx * dx;
    sqy    = dy * dy;
    dist_w = $unsigned(sqx) + $unsigned(sqy);
  end

  // dot product and leg lengths at the current corner
  cand_t cp, cq, cr;
  logic signed [COORD_W:0] ax, ay, bx, by;
  logic signed [31:0] pxx, pyy;
  logic signed [32:0] dot_w;
  logic [31:0] n1, n2, adot;

  always_comb begin
    case (step_q)
      CORNER_A: begin cp = ea_q; cq = eb_q; cr = ec_q; n1 = d_q[SIDE_AB]; n2 = d_q[SIDE_AC]; end
      CORNER_B: begin cp = eb_q; cq = ea_q; cr = ec_q; n1 = d_q[SIDE_AB]; n2 = d_q[SIDE_BC]; end
      default:  begin cp = ec_q; cq = ea_q; cr = eb_q; n1 = d_q[SIDE_AC]; n2 = d_q[SIDE_BC]; end
    endcase
    ax    = sdiff(cq.x, cp.x);
    ay    = sdiff(cq.y, cp.y);
    bx    = sdiff(cr.x, cp.x);
    by    = sdiff(cr.y, cp.y);
    pxx   = ax * bx;
    pyy   = ay * by;
    dot_w = {pxx[31], pxx} + {pyy[31], pyy};
    adot  = dot_q[32] ? 32'(-dot_q) : dot_q[31:0];
  end

  // side tests
  logic [31:0] mn, mx;
  logic [47:0] ratio_rhs;
  logic        skip;

  always_comb begin
    mn = d_q[SIDE_AB];
    mx = d_q[SIDE_AB];
    if (d_q[SIDE_BC] < mn) mn = d_q[SIDE_BC];
    if (d_q[SIDE_AC] < mn) mn = d_q[SIDE_AC];
    if (d_q[SIDE_BC] > mx) mx = d_q[SIDE_BC];
    if (d_q[SIDE_AC] > mx) mx = d_q[SIDE_AC];
    ratio_rhs = r2_q * mn;
    skip = (mn < {8'd0, ms2_q}) || ({8'd0, mx, 8'd0} > ratio_rhs);
  end

  // corner for the score: B before C before A on a tie
  logic [16:0] cmin_w;
  logic [31:0] dpq_w, dpr_w;

  always_comb begin
    cmin_w = cos_q[CORNER_A];
    if (cos_q[CORNER_B] < cmin_w) cmin_w = cos_q[CORNER_B];
    if (cos_q[CORNER_C] < cmin_w) cmin_w = cos_q[CORNER_C];
    if (cmin_w == cos_q[CORNER_B]) begin
      dpq_w = d_q[SIDE_AB]; dpr_w = d_q[SIDE_BC];
    end else if (cmin_w == cos_q[CORNER_C]) begin
      dpq_w = d_q[SIDE_AC]; dpr_w = d_q[SIDE_BC];
    end else begin
      dpq_w = d_q[SIDE_AB]; dpr_w = d_q[SIDE_AC];
    end
  end

  // leg penalty numerator and score
  logic [19:0] lmin, lmax;
  logic [27:0] pen_mul;
  logic [31:0] score_w;

  always_comb begin
    lmin    = (l1_q < l2_q) ? l1_q : l2_q;
    lmax    = (l1_q < l2_q) ? l2_q : l1_q;
    pen_mul = ratio_weight_q * (lmax - lmin);
    score_w = {15'd0, cmin_q} + pen_q;
  end

  // next triple in load order
  logic [CNT_W-1:0] ni, nj, nk;
  logic             adv_done;

  always_comb begin
    ni = i_q; nj = j_q; nk = k_q; adv_done = 1'b0;
    if (k_q + CNT_W'(1) < n_q) begin
      nk = k_q + CNT_W'(1);
    end else if (j_q + CNT_W'(2) < n_q) begin
      nj = j_q + CNT_W'(1);
      nk = j_q + CNT_W'(2);
    end else if (i_q + CNT_W'(3) < n_q) begin
      ni = i_q + CNT_W'(1);
      nj = i_q + CNT_W'(2);
      nk = i_q + CNT_W'(3);
    end else begin
      adv_done = 1'b1;
    end
  end

  // labeling corner: A before B before C on a tie, and cross product sign
  logic [1:0] lab_c;
  logic signed [COORD_W:0] v1x, v1y, v2x, v2y;
  logic signed [31:0] c1, c2;
  logic signed [32:0] cross_w;

  always_comb begin
    if (bcos_q[CORNER_A] <= bcos_q[CORNER_B] && bcos_q[CORNER_A] <= bcos_q[CORNER_C]) begin
      lab_c = CORNER_A;
    end else if (bcos_q[CORNER_B] <= bcos_q[CORNER_A] &&
                 bcos_q[CORNER_B] <= bcos_q[CORNER_C]) begin
      lab_c = CORNER_B;
    end else begin
      lab_c = CORNER_C;
    end
    v1x     = sdiff(lp1_q.x, lt_q.x);
    v1y     = sdiff(lp1_q.y, lt_q.y);
    v2x     = sdiff(lp2_q.x, lt_q.x);
    v2y     = sdiff(lp2_q.y, lt_q.y);
    c1      = v1x * v2y;
    c2      = v1y * v2x;
    cross_w = {c1[31], c1} - {c2[31], c2};
  end

  // drives of the store read port and the shared units
  always_comb begin
    ram_raddr = '0;
    sq_start  = 1'b0;
    sq_rad    = '0;
    dv_start  = 1'b0;
    dv_num    = '0;
    dv_den    = '0;
    case (state_q)
      S_RD_I: ram_raddr = i_q[IDX_W-1:0];
      S_RD_J: ram_raddr = j_q[IDX_W-1:0];
      S_RD_K: ram_raddr = k_q[IDX_W-1:0];
      S_PROD: begin
        sq_start = 1'b1;
        sq_rad   = n1 * n2;
      end
      S_ROOT: begin
        if (sq_done && (sq_root != '0)) begin
          dv_start = 1'b1;
          dv_num   = {adot, 16'd0};
          dv_den   = sq_root;
        end
      end
      S_SEL: begin
        sq_start = 1'b1;
        sq_rad   = {24'd0, dpq_w, 8'd0};
      end
      S_LEG1: begin
        if (sq_done) begin
          sq_start = 1'b1;
          sq_rad   = {24'd0, dpr_q, 8'd0};
        end
      end
      S_PEN: begin
        if (lmin != '0) begin
          dv_start = 1'b1;
          dv_num   = {12'd0, pen_mul, 8'd0};
          dv_den   = {12'd0, lmin};
        end
      end
      default: ;
    endcase
  end

  // configuration derived squares
  always_ff @(posedge clk_i) begin
    ms2_q <= min_spacing_q * min_spacing_q;
    r2_q  <= max_side_ratio_q * max_side_ratio_q;
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      ratio_weight_q   <= RW_RESET;
      min_spacing_q    <= MS_RESET;
      max_side_ratio_q <= MSR_RESET;
      cnt_q            <= '0;
      n_q              <= '0;
      i_q              <= '0;
      j_q              <= '0;
      k_q              <= '0;
      step_q           <= '0;
      best_score_q     <= '1;
      best_valid_q     <= 1'b0;
      res_valid_q      <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_RATIO_WEIGHT:   ratio_weight_q   <= cfg_i.data[RW_W-1:0];
          REG_MIN_SPACING:    min_spacing_q    <= cfg_i.data[MS_W-1:0];
          REG_MAX_SIDE_RATIO: max_side_ratio_q <= cfg_i.data[MSR_W-1:0];
          default: ;
        endcase
      end

      // hand-off of a held result; S_EMIT reloads it itself
      if (res_valid_q && res_o.ready && (state_q != S_EMIT)) begin
        res_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (cand_acc) begin
            cnt_q <= n_new;
            if (cand_i.last) begin
              cnt_q        <= '0;
              n_q          <= n_new;
              i_q          <= CNT_W'(0);
              j_q          <= CNT_W'(1);
              k_q          <= CNT_W'(2);
              best_score_q <= '1;
              best_valid_q <= 1'b0;
              state_q      <= (n_new < CNT_W'(3)) ? S_LABEL : S_RD_I;
            end
          end
        end
        S_RD_I: state_q <= S_RD_J;
        S_RD_J: begin
          ea_q    <= ram_rdata;
          state_q <= S_RD_K;
        end
        S_RD_K: begin
          eb_q    <= ram_rdata;
          state_q <= S_RD_W;
        end
        S_RD_W: begin
          ec_q    <= ram_rdata;
          step_q  <= SIDE_AB;
          state_q <= S_DIST;
        end
        S_DIST: begin
          d_q[step_q] <= dist_w;
          if (step_q == SIDE_AC) begin
            state_q <= S_TEST;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        S_TEST: begin
          if (skip) begin
            i_q <= ni; j_q <= nj; k_q <= nk;
            state_q <= adv_done ? S_LABEL : S_RD_I;
          end else begin
            step_q  <= CORNER_A;
            state_q <= S_DOT;
          end
        end
        S_DOT: begin
          dot_q   <= dot_w;
          state_q <= S_PROD;
        end
        S_PROD: state_q <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            if (sq_root == '0) begin
              cos_q[step_q] <= '0;
              if (step_q == CORNER_C) begin
                state_q <= S_SEL;
              end else begin
                step_q  <= step_q + 2'd1;
                state_q <= S_DOT;
              end
            end else begin
              state_q <= S_COSDIV;
            end
          end
        end
        S_COSDIV: begin
          if (dv_done) begin
            cos_q[step_q] <= (dv_quo > DIV_N_W'(COS_ONE)) ? COS_ONE : dv_quo[16:0];
            if (step_q == CORNER_C) begin
              state_q <= S_SEL;
            end else begin
              step_q  <= step_q + 2'd1;
              state_q <= S_DOT;
            end
          end
        end
        S_SEL: begin
          cmin_q  <= cmin_w;
          dpr_q   <= dpr_w;
          state_q <= S_LEG1;
        end
        S_LEG1: begin
          if (sq_done) begin
            l1_q    <= sq_root[19:0];
            state_q <= S_LEG2;
          end
        end
        S_LEG2: begin
          if (sq_done) begin
            l2_q    <= sq_root[19:0];
            state_q <= S_PEN;
          end
        end
        S_PEN: begin
          if (lmin == '0) begin
            pen_q   <= '0;
            state_q <= S_SCORE;
          end else begin
            state_q <= S_PENDIV;
          end
        end
        S_PENDIV: begin
          if (dv_done) begin
            pen_q   <= (dv_quo > {16'd0, PEN_SAT}) ? PEN_SAT : dv_quo[31:0];
            state_q <= S_SCORE;
          end
        end
        S_SCORE: begin
          if (score_w < best_score_q) begin
            best_score_q <= score_w;
            best_valid_q <= 1'b1;
            bea_q        <= ea_q;
            beb_q        <= eb_q;
            bec_q        <= ec_q;
            bcos_q       <= cos_q;
          end
          i_q <= ni; j_q <= nj; k_q <= nk;
          state_q <= adv_done ? S_LABEL : S_RD_I;
        end
        S_LABEL: begin
          case (lab_c)
            CORNER_A: begin lt_q <= bea_q; lp1_q <= beb_q; lp2_q <= bec_q; end
            CORNER_B: begin lt_q <= beb_q; lp1_q <= bea_q; lp2_q <= bec_q; end
            default:  begin lt_q <= bec_q; lp1_q <= bea_q; lp2_q <= beb_q; end
          endcase
          state_q <= best_valid_q ? S_CROSS : S_EMIT;
        end
        S_CROSS: begin
          // top-right is the first leg only for a positive cross product
          if (cross_w[32] || (cross_w == '0)) begin
            lp1_q <= lp2_q;
            lp2_q <= lp1_q;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_found_q <= best_valid_q;
            res_tl_q    <= best_valid_q ? lt_q  : '0;
            res_tr_q    <= best_valid_q ? lp1_q : '0;
            res_bl_q    <= best_valid_q ? lp2_q : '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.found   = res_found_q;
  assign res_o.tl_x    = res_tl_q.x;
  assign res_o.tl_y    = res_tl_q.y;
  assign res_o.tr_x    = res_tr_q.x;
  assign res_o.tr_y    = res_tr_q.y;
  assign res_o.bl_x    = res_bl_q.x;
  assign res_o.bl_y    = res_bl_q.y;
  assign res_o.tl_size = res_tl_q.size;
  assign res_o.tr_size = res_tr_q.size;
  assign res_o.bl_size = res_bl_q.size;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_CANDIDATES))
    else $error("candidate count beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIST) |-> (i_q < j_q && j_q < k_q && k_q < n_q))
    else $error("triple indices out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cand_acc && cand_i.last) |=> !cand_i.ready)
    else $error("input taken while a search starts");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> !dv_busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy)
    else $error("root unit restarted while busy");

endmodule
